// ----- design/rdfs_pkg.sv -----
// Shared types, constants and the arctangent table of the route distance summary block.
package rdfs_pkg;

    localparam int FEATURE_DEPTH = 64;
    localparam int CORDIC_STEPS  = 24;
    localparam int SQRT_STEPS    = 32;
    localparam int ADDR_W        = (FEATURE_DEPTH > 1) ? $clog2(FEATURE_DEPTH) : 1;
    localparam int FU_W          = $clog2(FEATURE_DEPTH + 1);
    localparam int ITER_W        = 5;
    localparam int CW            = 36;
    localparam int PW            = 72;
    localparam int SQW           = 64;

    localparam logic signed [CW-1:0] RAD_K       = 36'sd503056907;
    localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_X0   = 36'sd652032874;
    localparam logic [30:0]          ONE_Q30     = 31'd1073741824;
    localparam logic [23:0]          RADIUS_RST  = 24'd6371000;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_POINT  = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_FINISH,
        OP_POINT,
        OP_ANG_SRC,
        OP_ANG_MUL,
        OP_ANG_RND,
        OP_FOLD,
        OP_ROT,
        OP_SAVE,
        OP_M_CC,
        OP_M_LAT,
        OP_M_LON,
        OP_CAP_LON,
        OP_M_CT,
        OP_SUM,
        OP_SQRT,
        OP_VEC_INIT,
        OP_VEC,
        OP_SEG_MUL,
        OP_ACC,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic [1:0]         sel;
        logic [ITER_W-1:0]  iter;
    } dp_cmd_t;

    typedef struct packed {
        logic first_point;
        logic z_in_range;
        logic scan_done;
    } dp_sts_t;

    function automatic logic [29:0] atan_q30(input logic [ITER_W-1:0] i);
        logic [29:0] r;
        unique case (i)
            5'd0:  r = 30'h3243F6A8;
            5'd1:  r = 30'h1DAC6705;
            5'd2:  r = 30'h0FADBAFC;
            5'd3:  r = 30'h07F56EA6;
            5'd4:  r = 30'h03FEAB76;
            5'd5:  r = 30'h01FFD55B;
            5'd6:  r = 30'h00FFFAAA;
            5'd7:  r = 30'h007FFF55;
            5'd8:  r = 30'h003FFFEA;
            5'd9:  r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            5'd24: r = 30'h0000003F;
            5'd25: r = 30'h0000001F;
            5'd26: r = 30'h0000000F;
            5'd27: r = 30'h00000008;
            5'd28: r = 30'h00000004;
            5'd29: r = 30'h00000002;
            5'd30: r = 30'h00000001;
            default: r = 30'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ----- design/rdfs_datapath.sv -----
// Datapath: feature table, scan, shared multiplier, CORDIC, square roots and accumulators.
module rdfs_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rdfs_pkg::dp_cmd_t           cmd_i,
    output rdfs_pkg::dp_sts_t           sts,
    input  logic signed [30:0]          latitude_e7,
    input  logic signed [31:0]          longitude_e7,
    input  logic                        cfg_we,
    input  logic [23:0]                 cfg_data,
    output logic [31:0]                 point_total,
    output logic [31:0]                 feature_hits,
    output logic [31:0]                 distance_m,
    output logic                        table_overflow
);

    // control state
    logic [23:0]                    radius_reg;
    logic [rdfs_pkg::FU_W-1:0]      used_reg;
    logic                           ovf_reg;
    logic [31:0]                    points_reg;
    logic [31:0]                    hits_reg;
    logic [47:0]                    acc_reg;
    logic [31:0]                    prev_lat_reg;
    logic [31:0]                    prev_lon_reg;
    logic                           scan_active_reg;
    logic                           rd_vld_reg;
    logic                           hit_reg;
    logic [rdfs_pkg::ADDR_W-1:0]    scan_idx_reg;

    // payload
    logic [31:0]                    mem_lat [rdfs_pkg::FEATURE_DEPTH];
    logic [31:0]                    mem_lon [rdfs_pkg::FEATURE_DEPTH];
    logic [31:0]                    rd_lat_reg;
    logic [31:0]                    rd_lon_reg;
    logic [31:0]                    cur_lat_reg;
    logic [31:0]                    cur_lon_reg;
    logic [32:0]                    ang_mag_reg;
    logic                           ang_neg_reg;
    logic signed [rdfs_pkg::CW-1:0] x_reg, y_reg, z_reg;
    logic                           neg_reg;
    logic signed [rdfs_pkg::CW-1:0] sdlat_reg, sdlon_reg, c1_reg, c2_reg;
    logic signed [rdfs_pkg::CW-1:0] cc_reg, alat_reg, tl_reg;
    logic signed [rdfs_pkg::PW-1:0] prod_reg;
    logic [rdfs_pkg::SQW-1:0]       va_reg, vb_reg, ra_reg, rb_reg, bit_reg;
    logic [31:0]                    out_pc_reg, out_fh_reg, out_dm_reg;
    logic                           out_ov_reg;

    logic signed [rdfs_pkg::CW-1:0] mul_a, mul_b;
    logic signed [rdfs_pkg::CW-1:0] prod_q30;
    logic signed [rdfs_pkg::CW-1:0] sh_x, sh_y, at;
    logic signed [rdfs_pkg::CW-1:0] c_ang;
    logic signed [32:0]             e7_val;
    logic [63:0]                    rnd_sum, rnd_sh;
    logic signed [rdfs_pkg::CW-1:0] rnd_val;
    logic signed [36:0]             a_sum;
    logic [30:0]                    a_clamp;
    logic [rdfs_pkg::SQW-1:0]       ta, tb;
    logic [48:0]                    acc_sum;
    logic [42:0]                    seg;
    logic                           last_scan;

    assign prod_q30 = prod_reg[30+rdfs_pkg::CW-1:30];
    assign sh_x     = x_reg >>> cmd_i.iter;
    assign sh_y     = y_reg >>> cmd_i.iter;
    assign at       = rdfs_pkg::CW'(signed'({1'b0, rdfs_pkg::atan_q30(cmd_i.iter)}));
    assign c_ang    = z_reg[rdfs_pkg::CW-1] ? '0 : (z_reg <<< 1);
    assign last_scan = (rdfs_pkg::FU_W'(scan_idx_reg) + 1'b1) == used_reg;

    always_comb
    begin
        unique case (cmd_i.sel)
            2'd0:    e7_val = 33'(signed'(cur_lat_reg)) - 33'(signed'(prev_lat_reg));
            2'd1:    e7_val = 33'(signed'(cur_lon_reg)) - 33'(signed'(prev_lon_reg));
            2'd2:    e7_val = 33'(signed'(prev_lat_reg));
            default: e7_val = 33'(signed'(cur_lat_reg));
        endcase
    end

    // round half away from zero: 29 shift for half angles, 28 for full ones
    always_comb
    begin
        rnd_sum = prod_reg[63:0] + (cmd_i.sel[1] ? (64'd1 << 27) : (64'd1 << 28));
        rnd_sh  = cmd_i.sel[1] ? (rnd_sum >> 28) : (rnd_sum >> 29);
        rnd_val = rnd_sh[rdfs_pkg::CW-1:0];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd_i.op)
            rdfs_pkg::OP_ANG_MUL:
            begin
                mul_a = rdfs_pkg::CW'(ang_mag_reg);
                mul_b = rdfs_pkg::RAD_K;
            end
            rdfs_pkg::OP_M_CC:
            begin
                mul_a = c1_reg;
                mul_b = c2_reg;
            end
            rdfs_pkg::OP_M_LAT:
            begin
                mul_a = sdlat_reg;
                mul_b = sdlat_reg;
            end
            rdfs_pkg::OP_M_LON:
            begin
                mul_a = sdlon_reg;
                mul_b = sdlon_reg;
            end
            rdfs_pkg::OP_M_CT:
            begin
                mul_a = cc_reg;
                mul_b = tl_reg;
            end
            rdfs_pkg::OP_SEG_MUL:
            begin
                mul_a = rdfs_pkg::CW'(radius_reg);
                mul_b = c_ang;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        a_sum = 37'(alat_reg) + 37'(prod_q30);
        if (a_sum < 0)
            a_clamp = '0;
        else if (a_sum > 37'(rdfs_pkg::ONE_Q30))
            a_clamp = rdfs_pkg::ONE_Q30;
        else
            a_clamp = a_sum[30:0];
        ta      = ra_reg + bit_reg;
        tb      = rb_reg + bit_reg;
        seg     = prod_reg[56:14];
        acc_sum = {1'b0, acc_reg} + 49'(seg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= rdfs_pkg::RADIUS_RST;
            used_reg        <= '0;
            ovf_reg         <= 1'b0;
            points_reg      <= '0;
            hits_reg        <= '0;
            acc_reg         <= '0;
            prev_lat_reg    <= '0;
            prev_lon_reg    <= '0;
            scan_active_reg <= 1'b0;
            rd_vld_reg      <= 1'b0;
            hit_reg         <= 1'b0;
            scan_idx_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                radius_reg <= cfg_data;
            rd_vld_reg <= scan_active_reg;
            if (scan_active_reg)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (last_scan)
                    scan_active_reg <= 1'b0;
            end
            if (rd_vld_reg && rd_lat_reg == cur_lat_reg && rd_lon_reg == cur_lon_reg)
                hit_reg <= 1'b1;
            unique case (cmd_i.op)
                rdfs_pkg::OP_LOAD:
                begin
                    if (used_reg != rdfs_pkg::FU_W'(rdfs_pkg::FEATURE_DEPTH))
                        used_reg <= used_reg + 1'b1;
                    else
                        ovf_reg <= 1'b1;
                end
                rdfs_pkg::OP_CLEAR:
                begin
                    used_reg <= '0;
                    ovf_reg  <= 1'b0;
                end
                rdfs_pkg::OP_FINISH:
                begin
                    points_reg   <= '0;
                    hits_reg     <= '0;
                    acc_reg      <= '0;
                    prev_lat_reg <= '0;
                    prev_lon_reg <= '0;
                end
                rdfs_pkg::OP_POINT:
                begin
                    scan_idx_reg    <= '0;
                    scan_active_reg <= (used_reg != '0);
                    hit_reg         <= 1'b0;
                end
                rdfs_pkg::OP_ACC:
                    acc_reg <= acc_sum[48] ? '1 : acc_sum[47:0];
                rdfs_pkg::OP_COMMIT:
                begin
                    if (points_reg != '1)
                        points_reg <= points_reg + 1'b1;
                    if (hit_reg && hits_reg != '1)
                        hits_reg <= hits_reg + 1'b1;
                    prev_lat_reg <= cur_lat_reg;
                    prev_lon_reg <= cur_lon_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (cmd_i.op == rdfs_pkg::OP_LOAD && used_reg != rdfs_pkg::FU_W'(rdfs_pkg::FEATURE_DEPTH))
        begin
            mem_lat[used_reg[rdfs_pkg::ADDR_W-1:0]] <= 32'(latitude_e7);
            mem_lon[used_reg[rdfs_pkg::ADDR_W-1:0]] <= longitude_e7;
        end
        if (scan_active_reg)
        begin
            rd_lat_reg <= mem_lat[scan_idx_reg];
            rd_lon_reg <= mem_lon[scan_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd_i.op)
            rdfs_pkg::OP_FINISH:
            begin
                out_pc_reg <= points_reg;
                out_fh_reg <= hits_reg;
                out_dm_reg <= acc_reg[47:16];
                out_ov_reg <= ovf_reg;
            end
            rdfs_pkg::OP_POINT:
            begin
                cur_lat_reg <= 32'(latitude_e7);
                cur_lon_reg <= longitude_e7;
            end
            rdfs_pkg::OP_ANG_SRC:
            begin
                ang_neg_reg <= e7_val[32];
                ang_mag_reg <= e7_val[32] ? 33'(-e7_val) : 33'(e7_val);
            end
            rdfs_pkg::OP_ANG_MUL:
                prod_reg <= rdfs_pkg::PW'(mul_a) * rdfs_pkg::PW'(mul_b);
            rdfs_pkg::OP_ANG_RND:
            begin
                z_reg   <= ang_neg_reg ? -rnd_val : rnd_val;
                x_reg   <= rdfs_pkg::CORDIC_X0;
                y_reg   <= '0;
                neg_reg <= 1'b0;
            end
            rdfs_pkg::OP_FOLD:
            begin
                if (z_reg > rdfs_pkg::HALF_PI_Q30)
                begin
                    z_reg   <= z_reg - rdfs_pkg::PI_Q30;
                    neg_reg <= !neg_reg;
                end
                else if (z_reg < -rdfs_pkg::HALF_PI_Q30)
                begin
                    z_reg   <= z_reg + rdfs_pkg::PI_Q30;
                    neg_reg <= !neg_reg;
                end
            end
            rdfs_pkg::OP_ROT:
            begin
                if (!z_reg[rdfs_pkg::CW-1])
                begin
                    x_reg <= x_reg - sh_y;
                    y_reg <= y_reg + sh_x;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + sh_y;
                    y_reg <= y_reg - sh_x;
                    z_reg <= z_reg + at;
                end
            end
            rdfs_pkg::OP_SAVE:
            begin
                unique case (cmd_i.sel)
                    2'd0:    sdlat_reg <= neg_reg ? -y_reg : y_reg;
                    2'd1:    sdlon_reg <= neg_reg ? -y_reg : y_reg;
                    2'd2:    c1_reg    <= neg_reg ? -x_reg : x_reg;
                    default: c2_reg    <= neg_reg ? -x_reg : x_reg;
                endcase
            end
            rdfs_pkg::OP_M_CC:
                prod_reg <= rdfs_pkg::PW'(mul_a) * rdfs_pkg::PW'(mul_b);
            rdfs_pkg::OP_M_LAT:
            begin
                cc_reg   <= prod_q30;
                prod_reg <= rdfs_pkg::PW'(mul_a) * rdfs_pkg::PW'(mul_b);
            end
            rdfs_pkg::OP_M_LON:
            begin
                alat_reg <= prod_q30;
                prod_reg <= rdfs_pkg::PW'(mul_a) * rdfs_pkg::PW'(mul_b);
            end
            rdfs_pkg::OP_CAP_LON:
                tl_reg <= prod_q30;
            rdfs_pkg::OP_M_CT:
                prod_reg <= rdfs_pkg::PW'(mul_a) * rdfs_pkg::PW'(mul_b);
            rdfs_pkg::OP_SUM:
            begin
                va_reg  <= rdfs_pkg::SQW'(a_clamp) << 30;
                vb_reg  <= rdfs_pkg::SQW'(rdfs_pkg::ONE_Q30 - a_clamp) << 30;
                ra_reg  <= '0;
                rb_reg  <= '0;
                bit_reg <= rdfs_pkg::SQW'(1) << 62;
            end
            rdfs_pkg::OP_SQRT:
            begin
                if (va_reg >= ta)
                begin
                    va_reg <= va_reg - ta;
                    ra_reg <= (ra_reg >> 1) + bit_reg;
                end
                else
                    ra_reg <= ra_reg >> 1;
                if (vb_reg >= tb)
                begin
                    vb_reg <= vb_reg - tb;
                    rb_reg <= (rb_reg >> 1) + bit_reg;
                end
                else
                    rb_reg <= rb_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            rdfs_pkg::OP_VEC_INIT:
            begin
                x_reg <= rdfs_pkg::CW'(rb_reg[31:0]);
                y_reg <= rdfs_pkg::CW'(ra_reg[31:0]);
                z_reg <= '0;
            end
            rdfs_pkg::OP_VEC:
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + sh_y;
                    y_reg <= y_reg - sh_x;
                    z_reg <= z_reg + at;
                end
                else
                begin
                    x_reg <= x_reg - sh_y;
                    y_reg <= y_reg + sh_x;
                    z_reg <= z_reg - at;
                end
            end
            rdfs_pkg::OP_SEG_MUL:
                prod_reg <= rdfs_pkg::PW'(mul_a) * rdfs_pkg::PW'(mul_b);
            default:
            begin
            end
        endcase
    end

    assign sts.first_point = (points_reg == '0);
    assign sts.z_in_range  = !(z_reg > rdfs_pkg::HALF_PI_Q30) && !(z_reg < -rdfs_pkg::HALF_PI_Q30);
    assign sts.scan_done   = !scan_active_reg && !rd_vld_reg;

    assign point_total    = out_pc_reg;
    assign feature_hits   = out_fh_reg;
    assign distance_m     = out_dm_reg;
    assign table_overflow = out_ov_reg;

endmodule

// ----- design/rdfs_ctrl.sv -----
// Controller: sequences the datapath for each item and owns the result valid.
module rdfs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output rdfs_pkg::dp_cmd_t   dp_cmd,
    input  rdfs_pkg::dp_sts_t   sts
);

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_ANG_SRC  = 19'h00002,
        S_ANG_MUL  = 19'h00004,
        S_ANG_RND  = 19'h00008,
        S_FOLD     = 19'h00010,
        S_ROT      = 19'h00020,
        S_SAVE     = 19'h00040,
        S_M_CC     = 19'h00080,
        S_M_LAT    = 19'h00100,
        S_M_LON    = 19'h00200,
        S_CAP_LON  = 19'h00400,
        S_M_CT     = 19'h00800,
        S_SUM      = 19'h01000,
        S_SQRT     = 19'h02000,
        S_VEC_INIT = 19'h04000,
        S_VEC      = 19'h08000,
        S_SEG_MUL  = 19'h10000,
        S_ACC      = 19'h20000,
        S_WAIT     = 19'h40000
    } state_t;

    state_t                         state_reg, state_next;
    logic [1:0]                     sel_reg, sel_next;
    logic [rdfs_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           accept;
    logic                           rot_last, sqrt_last;

    assign in_ready = (state_reg == S_IDLE) &&
                      (cmd != rdfs_pkg::CMD_FINISH || !out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign rot_last  = iter_reg == rdfs_pkg::ITER_W'(rdfs_pkg::CORDIC_STEPS - 1);
    assign sqrt_last = iter_reg == rdfs_pkg::ITER_W'(rdfs_pkg::SQRT_STEPS - 1);

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        dp_cmd.op      = rdfs_pkg::OP_NOP;
        dp_cmd.sel     = sel_reg;
        dp_cmd.iter    = iter_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        rdfs_pkg::CMD_LOAD:   dp_cmd.op = rdfs_pkg::OP_LOAD;
                        rdfs_pkg::CMD_CLEAR:  dp_cmd.op = rdfs_pkg::OP_CLEAR;
                        rdfs_pkg::CMD_FINISH:
                        begin
                            dp_cmd.op      = rdfs_pkg::OP_FINISH;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            dp_cmd.op  = rdfs_pkg::OP_POINT;
                            sel_next   = '0;
                            state_next = sts.first_point ? S_WAIT : S_ANG_SRC;
                        end
                    endcase
                end
            end
            S_ANG_SRC:
            begin
                dp_cmd.op  = rdfs_pkg::OP_ANG_SRC;
                state_next = S_ANG_MUL;
            end
            S_ANG_MUL:
            begin
                dp_cmd.op  = rdfs_pkg::OP_ANG_MUL;
                state_next = S_ANG_RND;
            end
            S_ANG_RND:
            begin
                dp_cmd.op  = rdfs_pkg::OP_ANG_RND;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                dp_cmd.op = rdfs_pkg::OP_FOLD;
                if (sts.z_in_range)
                begin
                    iter_next  = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                dp_cmd.op = rdfs_pkg::OP_ROT;
                iter_next = iter_reg + 1'b1;
                if (rot_last)
                    state_next = S_SAVE;
            end
            S_SAVE:
            begin
                dp_cmd.op = rdfs_pkg::OP_SAVE;
                sel_next  = sel_reg + 1'b1;
                state_next = (sel_reg == 2'd3) ? S_M_CC : S_ANG_SRC;
            end
            S_M_CC:
            begin
                dp_cmd.op  = rdfs_pkg::OP_M_CC;
                state_next = S_M_LAT;
            end
            S_M_LAT:
            begin
                dp_cmd.op  = rdfs_pkg::OP_M_LAT;
                state_next = S_M_LON;
            end
            S_M_LON:
            begin
                dp_cmd.op  = rdfs_pkg::OP_M_LON;
                state_next = S_CAP_LON;
            end
            S_CAP_LON:
            begin
                dp_cmd.op  = rdfs_pkg::OP_CAP_LON;
                state_next = S_M_CT;
            end
            S_M_CT:
            begin
                dp_cmd.op  = rdfs_pkg::OP_M_CT;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                dp_cmd.op  = rdfs_pkg::OP_SUM;
                iter_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                dp_cmd.op = rdfs_pkg::OP_SQRT;
                iter_next = iter_reg + 1'b1;
                if (sqrt_last)
                    state_next = S_VEC_INIT;
            end
            S_VEC_INIT:
            begin
                dp_cmd.op  = rdfs_pkg::OP_VEC_INIT;
                iter_next  = '0;
                state_next = S_VEC;
            end
            S_VEC:
            begin
                dp_cmd.op = rdfs_pkg::OP_VEC;
                iter_next = iter_reg + 1'b1;
                if (rot_last)
                    state_next = S_SEG_MUL;
            end
            S_SEG_MUL:
            begin
                dp_cmd.op  = rdfs_pkg::OP_SEG_MUL;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                dp_cmd.op  = rdfs_pkg::OP_ACC;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.scan_done)
                begin
                    dp_cmd.op  = rdfs_pkg::OP_COMMIT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == rdfs_pkg::CMD_FINISH) |=> out_valid_reg)
        else $error("finish beat did not raise a result");

    a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT || state_reg == S_VEC) |->
        (iter_reg < rdfs_pkg::ITER_W'(rdfs_pkg::CORDIC_STEPS)))
        else $error("CORDIC step count overran");

    a_wait_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && !sts.scan_done) |=> state_reg == S_WAIT)
        else $error("point committed before table scan finished");
`endif

endmodule

// ----- design/route_distance_feature_summary_unit.sv -----
// Load, clear and finish complete on acceptance; a finish result is valid the next cycle.
// A route point keeps the block busy through four rotation CORDIC passes (an angle outside
// [-pi/2, pi/2] is first folded by pi), the multiply and sum steps, a 32-step dual square root,
// a 24-step vectoring CORDIC and scale/accumulate/commit. The table scan (one entry per cycle)
// runs beside it; a route's first point waits only for the scan. The block takes one item at a
// time. Reset (rst_n, async low): empty table, route counters cleared, radius 6371000 m.
module route_distance_feature_summary_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic signed [30:0]  latitude_e7,
    input  logic signed [31:0]  longitude_e7,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         point_total,
    output logic [31:0]         feature_hits,
    output logic [31:0]         distance_m,
    output logic                table_overflow,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [23:0]         cfg_data
);

    rdfs_pkg::dp_cmd_t dp_cmd;
    rdfs_pkg::dp_sts_t dp_sts;

    // The radius register takes a beat whenever one is offered.
    assign cfg_ready = 1'b1;

    // Controller: steps through the segment math and holds the result valid.
    rdfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd),
        .sts       (dp_sts)
    );

    // Datapath: table, scan, trig, roots and accumulators; drives result payload.
    rdfs_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_i          (dp_cmd),
        .sts            (dp_sts),
        .latitude_e7    (latitude_e7),
        .longitude_e7   (longitude_e7),
        .cfg_we         (cfg_valid),
        .cfg_data       (cfg_data),
        .point_total    (point_total),
        .feature_hits   (feature_hits),
        .distance_m     (distance_m),
        .table_overflow (table_overflow)
    );

endmodule

// ----- test/tb_route_distance_feature_summary_unit.sv -----
// Testbench of the route distance and feature summary unit: directed table, table overflow, then random routes.
module tb_route_distance_feature_summary_unit;

    typedef struct {
        logic [31:0] point_total;
        logic [31:0] feature_hits;
        logic [31:0] distance_m;
        logic        table_overflow;
    } summary_t;

    typedef struct {
        rdfs_pkg::cmd_t op;
        longint         lat;
        longint         lon;
        bit             typed;
        summary_t       sum;
    } stim_row_t;

    localparam longint unsigned DIST_ACC_MAX = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned COUNT_MAX    = 64'hFFFF_FFFF;
    localparam int              SETTLE_CYC   = 250;
    localparam int              RANDOM_ITEMS = 1600;
    localparam longint          LAT_FIELD_MIN = -64'sd1073741824;
    localparam longint          LAT_FIELD_MAX = 64'sd1073741823;
    localparam longint          LON_FIELD_MIN = -64'sd2147483648;
    localparam longint          LON_FIELD_MAX = 64'sd2147483647;

    // Arctangent of 2^-i in Q30 radians.
    localparam longint ARCTAN_Q30 [32] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001, 'h00000000
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic signed [30:0] latitude_e7;
    logic signed [31:0] longitude_e7;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        point_total;
    logic [31:0]        feature_hits;
    logic [31:0]        distance_m;
    logic               table_overflow;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [23:0]        cfg_data;

    route_distance_feature_summary_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .latitude_e7    (latitude_e7),
        .longitude_e7   (longitude_e7),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .point_total    (point_total),
        .feature_hits   (feature_hits),
        .distance_m     (distance_m),
        .table_overflow (table_overflow),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // Mirror of the block state
    longint unsigned radius_m;
    longint          stored_lat [rdfs_pkg::FEATURE_DEPTH];
    longint          stored_lon [rdfs_pkg::FEATURE_DEPTH];
    int              stored_count;
    longint          last_lat;
    longint          last_lon;
    longint unsigned route_points;
    longint unsigned route_hits;
    longint unsigned dist_acc_q16;
    bit              dropped_load;

    summary_t  pending_summaries [$];
    stim_row_t stim_rows [$];
    int        mismatch_count;
    bit        sender_no_idle;
    bit        sink_no_idle;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------- fixed-point predictor ----------------

    // Degrees e7 to Q30 radians, rounded half away from zero.
    function automatic longint e7_to_q30(input longint e7, input int sh);
        longint unsigned mag;
        longint unsigned r;
        mag = (e7 < 0) ? longint'(-e7) : e7;
        r   = (mag * longint'(rdfs_pkg::RAD_K) + (64'd1 << (sh - 1))) >> sh;
        return (e7 < 0) ? -longint'(r) : longint'(r);
    endfunction

    // Rotation CORDIC with folding into [-pi/2, pi/2].
    function automatic void rotate_q30(input longint z, output longint sn, output longint cs);
        longint x;
        longint y;
        longint t;
        bit     flip;
        x    = longint'(rdfs_pkg::CORDIC_X0);
        y    = 0;
        flip = 1'b0;
        while (z > longint'(rdfs_pkg::HALF_PI_Q30))
        begin
            z    = z - longint'(rdfs_pkg::PI_Q30);
            flip = ~flip;
        end
        while (z < -longint'(rdfs_pkg::HALF_PI_Q30))
        begin
            z    = z + longint'(rdfs_pkg::PI_Q30);
            flip = ~flip;
        end
        for (int i = 0; i < rdfs_pkg::CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                x = t;
                z = z - ARCTAN_Q30[i];
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                x = t;
                z = z + ARCTAN_Q30[i];
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic longint vector_angle_q30(input longint y, input longint x);
        longint z;
        longint t;
        z = 0;
        for (int i = 0; i < rdfs_pkg::CORDIC_STEPS; i++)
        begin
            if (y > 0)
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                x = t;
                z = z + ARCTAN_Q30[i];
            end
            else
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                x = t;
                z = z - ARCTAN_Q30[i];
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b    = 64'd1 << 62;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v    = v - (root + b);
                root = (root >> 1) + b;
            end
            else
            begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // Haversine segment length in metres with 16 fraction bits.
    function automatic longint unsigned hop_length_q16(input longint lat1, input longint lon1,
                                                       input longint lat2, input longint lon2);
        longint s_dlat;
        longint s_dlon;
        longint c1;
        longint c2;
        longint unused;
        longint cc;
        longint a;
        longint sa;
        longint sb;
        longint ang;
        rotate_q30(e7_to_q30(lat2 - lat1, 29), s_dlat, unused);
        rotate_q30(e7_to_q30(lon2 - lon1, 29), s_dlon, unused);
        rotate_q30(e7_to_q30(lat1, 28), unused, c1);
        rotate_q30(e7_to_q30(lat2, 28), unused, c2);
        cc = (c1 * c2) >>> 30;
        a  = ((s_dlat * s_dlat) >>> 30) + ((cc * ((s_dlon * s_dlon) >>> 30)) >>> 30);
        if (a < 0)
            a = 0;
        if (a > longint'(rdfs_pkg::ONE_Q30))
            a = longint'(rdfs_pkg::ONE_Q30);
        sa  = floor_root(longint'(a) << 30);
        sb  = floor_root((longint'(rdfs_pkg::ONE_Q30) - a) << 30);
        ang = 2 * vector_angle_q30(sa, sb);
        return (radius_m * longint'(ang)) >> 14;
    endfunction

    // Advance the mirror by one accepted item; return 1 when a summary comes out.
    function automatic bit apply_item(input rdfs_pkg::cmd_t op, input longint lat,
                                      input longint lon, output summary_t sum);
        bit              hit;
        longint unsigned hop;
        hit = 1'b0;
        sum = '{default: '0};
        unique case (op)
            rdfs_pkg::CMD_LOAD:
            begin
                if (stored_count < rdfs_pkg::FEATURE_DEPTH)
                begin
                    stored_lat[stored_count] = lat;
                    stored_lon[stored_count] = lon;
                    stored_count++;
                end
                else
                begin
                    dropped_load = 1'b1;
                end
            end
            rdfs_pkg::CMD_POINT:
            begin
                for (int i = 0; i < stored_count; i++)
                    if (stored_lat[i] == lat && stored_lon[i] == lon)
                        hit = 1'b1;
                if (route_points != 0)
                begin
                    hop = hop_length_q16(last_lat, last_lon, lat, lon);
                    dist_acc_q16 = (hop > DIST_ACC_MAX - dist_acc_q16) ? DIST_ACC_MAX
                                                                       : dist_acc_q16 + hop;
                end
                if (route_points < COUNT_MAX)
                    route_points++;
                if (hit && route_hits < COUNT_MAX)
                    route_hits++;
                last_lat = lat;
                last_lon = lon;
            end
            rdfs_pkg::CMD_FINISH:
            begin
                sum.point_total    = route_points[31:0];
                sum.feature_hits   = route_hits[31:0];
                sum.distance_m     = dist_acc_q16[47:16];
                sum.table_overflow = dropped_load;
                route_points = 0;
                route_hits   = 0;
                dist_acc_q16 = 0;
                last_lat     = 0;
                last_lon     = 0;
                return 1'b1;
            end
            default:
            begin
                stored_count = 0;
                dropped_load = 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    // ---------------- drivers ----------------

    // Offer one beat after a random gap, hold it until taken, then predict.
    task automatic send_item(input rdfs_pkg::cmd_t op, input longint lat, input longint lon,
                             input bit typed, input summary_t typed_sum);
        int       gap;
        summary_t sum;
        gap = sender_no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        latitude_e7  <= lat[30:0];
        longitude_e7 <= lon[31:0];
        do
            @(posedge clk);
        while (!in_ready);
        if (apply_item(op, lat, lon, sum))
            pending_summaries.insert(pending_summaries.size(), typed ? typed_sum : sum);
        if ($urandom_range(0, 60) == 0)
            sender_no_idle = ~sender_no_idle;
    endtask

    task automatic send_plain(input rdfs_pkg::cmd_t op, input longint lat, input longint lon);
        send_item(op, lat, lon, 1'b0, '{default: '0});
    endtask

    // Append one row to the directed table.
    function automatic void add_row(input rdfs_pkg::cmd_t op, input longint lat,
                                    input longint lon, input bit typed, input summary_t sum);
        stim_row_t row;
        row.op    = op;
        row.lat   = lat;
        row.lon   = lon;
        row.typed = typed;
        row.sum   = sum;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // Wait until the block is idle: every summary in, then the point latency.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_summaries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_radius(input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius_m  = value;
    endtask

    function automatic longint any_lat;
        logic signed [30:0] raw;
        if ($urandom_range(0, 3) == 0)
        begin
            raw = 31'($urandom);
            return raw;
        end
        return longint'($urandom_range(0, 1800000000)) - 900000000;
    endfunction

    function automatic longint any_lon;
        logic signed [31:0] raw;
        if ($urandom_range(0, 3) == 0)
        begin
            raw = $urandom;
            return raw;
        end
        return longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
    endfunction

    // One random item; routes dominate, points often revisit stored features or step nearby.
    task automatic send_random_item;
        int     pick;
        int     idx;
        longint lat;
        longint lon;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            send_plain(rdfs_pkg::CMD_FINISH, any_lat(), any_lon());
        else if (pick < 19)
            send_plain(rdfs_pkg::CMD_LOAD, any_lat(), any_lon());
        else if (pick < 22)
            send_plain(rdfs_pkg::CMD_CLEAR, any_lat(), any_lon());
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3 && stored_count > 0)
            begin
                idx = $urandom_range(0, stored_count - 1);
                lat = stored_lat[idx];
                lon = stored_lon[idx];
            end
            else if (pick < 6)
            begin
                // Keep the step inside the field width
                lat = last_lat + $signed($urandom_range(0, 200000)) - 100000;
                lon = last_lon + $signed($urandom_range(0, 200000)) - 100000;
                if (lat > LAT_FIELD_MAX || lat < LAT_FIELD_MIN)
                    lat = 0;
                if (lon > LON_FIELD_MAX || lon < LON_FIELD_MIN)
                    lon = 0;
            end
            else
            begin
                lat = any_lat();
                lon = any_lon();
            end
            send_plain(rdfs_pkg::CMD_POINT, lat, lon);
        end
    endtask

    // ---------------- result sink and checker ----------------

    initial
    begin
        int       gap;
        summary_t want;
        out_ready      <= 1'b0;
        mismatch_count = 0;
        sink_no_idle   = 1'b0;
        forever
        begin
            gap = sink_no_idle ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_summaries.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected summary beat: points %0d hits %0d dist %0d ovf %0b",
                             point_total, feature_hits, distance_m, table_overflow);
            end
            else
            begin
                want = pending_summaries.pop_front();
                if (want.point_total !== point_total || want.feature_hits !== feature_hits ||
                    want.distance_m !== distance_m || want.table_overflow !== table_overflow)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("summary mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 want.point_total, want.feature_hits, want.distance_m,
                                 want.table_overflow, point_total, feature_hits,
                                 distance_m, table_overflow);
                end
            end
            if ($urandom_range(0, 20) == 0)
                sink_no_idle = ~sink_no_idle;
        end
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #40000000;
        $display("Verification failed");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial
    begin
        summary_t      zero_sum;
        logic [23:0]   radii [6];
        int            per_phase;

        // Drive every input to a known level before reset lifts
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        cmd          <= rdfs_pkg::CMD_LOAD;
        latitude_e7  <= '0;
        longitude_e7 <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;

        radius_m       = rdfs_pkg::RADIUS_RST;
        stored_count   = 0;
        last_lat       = 0;
        last_lon       = 0;
        route_points   = 0;
        route_hits     = 0;
        dist_acc_q16   = 0;
        dropped_load   = 1'b0;
        sender_no_idle = 1'b0;
        zero_sum       = '{default: '0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: typed sums where they are obvious, predictor elsewhere
        add_row(rdfs_pkg::CMD_FINISH, 0, 0, 1'b1, zero_sum);
        add_row(rdfs_pkg::CMD_POINT, 0, 0, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_FINISH, 0, 0, 1'b1, '{32'd1, 32'd0, 32'd0, 1'b0});
        add_row(rdfs_pkg::CMD_LOAD, 900000000, 1800000000, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_LOAD, -900000000, -1800000000, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_POINT, 900000000, 1800000000, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_POINT, -900000000, -1800000000, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_POINT, 0, 1800000000, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_FINISH, 0, 0, 1'b0, zero_sum);
        // Field extremes, far outside the legal degree range
        add_row(rdfs_pkg::CMD_POINT, LAT_FIELD_MIN, LON_FIELD_MIN, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_POINT, LAT_FIELD_MAX, LON_FIELD_MAX, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_POINT, LAT_FIELD_MAX, LON_FIELD_MIN, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_FINISH, 0, 0, 1'b0, zero_sum);
        // Clear leaves the route alone but empties the table
        add_row(rdfs_pkg::CMD_POINT, 10, 20, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_CLEAR, 0, 0, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_POINT, 900000000, 1800000000, 1'b0, zero_sum);
        add_row(rdfs_pkg::CMD_FINISH, 0, 0, 1'b0, zero_sum);
        foreach (stim_rows[i])
            send_item(stim_rows[i].op, stim_rows[i].lat, stim_rows[i].lon,
                      stim_rows[i].typed, stim_rows[i].sum);

        // Fill the table past its depth, then check the sticky drop flag and its clear
        for (int i = 0; i <= rdfs_pkg::FEATURE_DEPTH; i++)
            send_plain(rdfs_pkg::CMD_LOAD, i * 1000, -i * 1000);
        send_plain(rdfs_pkg::CMD_POINT, rdfs_pkg::FEATURE_DEPTH * 1000,
                   -rdfs_pkg::FEATURE_DEPTH * 1000);
        send_plain(rdfs_pkg::CMD_POINT, 63000, -63000);
        send_plain(rdfs_pkg::CMD_FINISH, 0, 0);
        send_item(rdfs_pkg::CMD_FINISH, 0, 0, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1});
        send_plain(rdfs_pkg::CMD_CLEAR, 0, 0);
        send_item(rdfs_pkg::CMD_FINISH, 0, 0, 1'b1, zero_sum);

        // Random phases, each under its own radius; reset value first, then the extremes
        radii[0]  = rdfs_pkg::RADIUS_RST;
        radii[1]  = 24'hFFFFFF;
        radii[2]  = 24'd1;
        radii[3]  = 24'd0;
        radii[4]  = 24'($urandom_range(1, 24'hFFFFFF));
        radii[5]  = rdfs_pkg::RADIUS_RST;
        per_phase = RANDOM_ITEMS / 6;
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                write_radius(radii[ph]);
            end
            if (ph == 1)
            begin
                // Antipodal hops at the largest radius drive the accumulator into saturation
                for (int k = 0; k < 100; k++)
                    send_plain(rdfs_pkg::CMD_POINT, 0, (k % 2) ? 1800000000 : 0);
                send_plain(rdfs_pkg::CMD_FINISH, 0, 0);
            end
            for (int k = 0; k < per_phase; k++)
                send_random_item();
            send_plain(rdfs_pkg::CMD_FINISH, 0, 0);
        end

        drain();
        if (mismatch_count == 0 && pending_summaries.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
